// ----- rtl/mclb_pkg.sv -----
package mclb_pkg;

    localparam int CHANNELS_DEFAULT = 7;
    localparam int LED_COUNT = 7;

    localparam int KIND_W = 2;
    localparam int LED_NUM_W = 3;
    localparam int DUR_W = 16;
    localparam int TIME_W = 32;
    localparam int PERIOD_W = 8;

    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 8;

    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RESET = 8'd10;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLINK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LED_NUM_W-1:0] led_number;
        logic level;
        logic [DUR_W-1:0] on_duration;
        logic [DUR_W-1:0] off_duration;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic tick_ok;
        logic [TIME_W-1:0] now_ms;
        logic [DUR_W-1:0] on_duration;
        logic [DUR_W-1:0] off_duration;
    } chan_ctl_t;

    typedef struct packed {
        logic flip;
        logic lit;
    } chan_stat_t;

endpackage

// ----- rtl/mclb_channel.sv -----
module mclb_channel (
    input  logic                clk,
    input  logic                rst_n,
    input  mclb_pkg::chan_ctl_t ctl,
    input  logic                start,
    output mclb_pkg::chan_stat_t stat
);
    import mclb_pkg::*;

    logic [TIME_W-1:0] phase_start_reg;
    logic [TIME_W-1:0] phase_start_next;
    logic [DUR_W-1:0] on_time_reg;
    logic [DUR_W-1:0] on_time_next;
    logic [DUR_W-1:0] dark_time_reg;
    logic [DUR_W-1:0] dark_time_next;
    logic in_on_reg;
    logic in_on_next;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic armed;
    logic flip;

    assign elapsed = ctl.now_ms - phase_start_reg;
    assign limit = in_on_reg ? {{(TIME_W-DUR_W){1'b0}}, on_time_reg}
                             : {{(TIME_W-DUR_W){1'b0}}, dark_time_reg};
    assign armed = (on_time_reg != '0) && (dark_time_reg != '0);
    assign flip = ctl.tick_ok && armed && (elapsed >= limit);

    assign stat.flip = flip;
    assign stat.lit = ~in_on_reg;

    always_comb
    begin
        phase_start_next = phase_start_reg;
        on_time_next = on_time_reg;
        dark_time_next = dark_time_reg;
        in_on_next = in_on_reg;
        if (start)
        begin
            phase_start_next = ctl.now_ms;
            on_time_next = ctl.on_duration;
            dark_time_next = ctl.off_duration;
            in_on_next = 1'b1;
        end
        else if (flip)
        begin
            phase_start_next = ctl.now_ms;
            in_on_next = ~in_on_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_start_reg <= '0;
            on_time_reg <= '0;
            dark_time_reg <= '0;
            in_on_reg <= 1'b0;
        end
        else
        begin
            phase_start_reg <= phase_start_next;
            on_time_reg <= on_time_next;
            dark_time_reg <= dark_time_next;
            in_on_reg <= in_on_next;
        end
    end

endmodule

// ----- rtl/multi_channel_led_blinker.sv -----
// Channel   Handshake                     Contents
// s_axis    tvalid/tready, tdata, tuser   one command word per transfer
// m_axis    tvalid/tready, tdata          LED levels after each command
// cfg       cfg_we, cfg_wdata             update period in milliseconds
//
// One word is taken per cycle while s_axis_tready is high; its result reaches m_axis
// through the input register and the result register, which each hold one word, and all
// blink channels compare elapsed time in parallel between the two registers.
// Reset clears every LED and channel and sets the update period to 10 ms.
// A stalled result holds the result register while the input register still
// takes one more word.
module multi_channel_led_blinker #(
    parameter int CHANNELS = mclb_pkg::CHANNELS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // led_number[2:0], level[3], on_duration[19:4], off_duration[35:20],
    // now_ms[67:36], zero fill[71:68].
    input  logic [mclb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind[1:0].
    input  logic [mclb_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // led_bits[6:0], zero fill[7].
    output logic [mclb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [mclb_pkg::PERIOD_W-1:0]      cfg_wdata
);
    import mclb_pkg::*;

    item_t item_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic proc_ready;
    logic proc_fire;
    logic in_fire;

    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0] last_tick_reg;
    logic [TIME_W-1:0] last_tick_next;
    logic [LED_COUNT-1:0] led_reg;
    logic [LED_COUNT-1:0] led_next;

    logic [TIME_W-1:0] since_tick;
    logic tick_ok;
    logic num_valid;
    logic [LED_NUM_W-1:0] ch_idx;
    logic [CHANNELS-1:0] sel;
    logic [CHANNELS-1:0] start;
    chan_ctl_t ctl;
    chan_stat_t stat [CHANNELS];

    assign proc_ready = !out_valid_reg || m_axis_tready;
    assign proc_fire = in_valid_reg && proc_ready;
    assign s_axis_tready = !in_valid_reg || proc_ready;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign since_tick = item_reg.now_ms - last_tick_reg;
    assign tick_ok = proc_fire && (item_reg.kind == KIND_TICK)
                     && (since_tick >= {{(TIME_W-PERIOD_W){1'b0}}, period_reg});

    assign num_valid = (item_reg.led_number != '0)
                       && ({1'b0, item_reg.led_number} <= 4'(CHANNELS))
                       && ({1'b0, item_reg.led_number} <= 4'(LED_COUNT));
    assign ch_idx = item_reg.led_number - 3'd1;

    assign ctl.tick_ok = tick_ok;
    assign ctl.now_ms = item_reg.now_ms;
    assign ctl.on_duration = item_reg.on_duration;
    assign ctl.off_duration = item_reg.off_duration;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        assign sel[c] = num_valid && (ch_idx == 3'(c));
        assign start[c] = proc_fire && (item_reg.kind == KIND_BLINK) && sel[c];

        mclb_channel u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .start (start[c]),
            .stat  (stat[c])
        );
    end

    always_comb
    begin
        led_next = led_reg;
        last_tick_next = last_tick_reg;
        unique case (item_reg.kind)
            KIND_TICK:
            begin
                if (tick_ok)
                begin
                    last_tick_next = item_reg.now_ms;
                end
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (c < LED_COUNT && stat[c].flip)
                    begin
                        led_next[c] = stat[c].lit;
                    end
                end
            end
            KIND_BLINK:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (c < LED_COUNT && sel[c])
                    begin
                        led_next[c] = 1'b1;
                    end
                end
            end
            KIND_SET:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (c < LED_COUNT && sel[c])
                    begin
                        led_next[c] = item_reg.level;
                    end
                end
            end
            KIND_TOGGLE:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (c < LED_COUNT && sel[c])
                    begin
                        led_next[c] = ~led_reg[c];
                    end
                end
            end
            default:
            begin
                led_next = led_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.kind <= s_axis_tuser;
            item_reg.led_number <= s_axis_tdata[2:0];
            item_reg.level <= s_axis_tdata[3];
            item_reg.on_duration <= s_axis_tdata[19:4];
            item_reg.off_duration <= s_axis_tdata[35:20];
            item_reg.now_ms <= s_axis_tdata[67:36];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg <= UPDATE_PERIOD_RESET;
            last_tick_reg <= '0;
            led_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            if (proc_fire)
            begin
                last_tick_reg <= last_tick_next;
                led_reg <= led_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(OUT_DATA_W-LED_COUNT){1'b0}}, led_reg};

`ifndef SYNTH
    a_set_first_led: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && item_reg.kind == KIND_SET && item_reg.led_number == 3'd1
        |=> led_reg[0] == $past(item_reg.level))
        else $error("set command did not reach LED 1");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire))
        else $error("result appeared without a processed word");

    a_rejected_tick: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && item_reg.kind == KIND_TICK && !tick_ok |=> $stable(last_tick_reg))
        else $error("rejected tick moved the tick time");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled while a stage was free");
`endif

endmodule
